>>> src/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table.
// Holds the controller state type, the command and status structs and the beat layouts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  // Default build parameters.
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_DATA_BITS   = 32;

  // Configuration register.
  localparam int              CFG_W          = 11;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

  // Input beat layout: tdata holds key, data_in and home_slot from the low bit up.
  localparam int IN_TDATA_W = 80;
  localparam int IN_TUSER_W = 2;
  localparam int FIELD_W    = 32;
  localparam int KEY_LSB    = 0;
  localparam int DATA_LSB   = 32;
  localparam int HOME_LSB   = 64;
  localparam int HOME_W     = 10;

  // Output beat layout: tdata holds data_out, tuser holds status.
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;

  // Operation codes.
  localparam logic [IN_TUSER_W-1:0] OP_INSERT = 2'd0;
  localparam logic [IN_TUSER_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [IN_TUSER_W-1:0] OP_SEARCH = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Home slot reduction: two remainder bits per cycle.
  localparam int MOD_RADIX_BITS = 2;
  localparam int MOD_STEPS      = HOME_W / MOD_RADIX_BITS;
  localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_we;
    logic load;
    logic mod_step;
    logic probe_init;
    logic advance;
    logic wr_entry;
    logic wr_del;
    logic set_ok;
    logic set_found;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic mod_done;
    logic op_insert;
    logic op_lookup;
    logic op_remove;
    logic slot_free;
    logic slot_empty;
    logic key_match;
    logic last_probe;
  } sts_t;

endpackage

`default_nettype wire

>>> src/lpht_ctrl.sv
// Controller for the linear-probing hash table: clearing pass, request sequencing
// and the output valid flag. Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t     cmd
);
  import lpht_pkg::*;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  // The output register can take a result when empty or being drained this cycle.
  assign out_free = !out_tvalid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (sts.mod_done) begin
          if (sts.op_insert || sts.op_lookup) state_nxt = ST_READ;
          else                                state_nxt = ST_RESP;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.op_insert) begin
          if (sts.slot_free || sts.last_probe) state_nxt = ST_RESP;
          else                                 state_nxt = ST_READ;
        end else begin
          if (sts.slot_empty || sts.key_match || sts.last_probe) state_nxt = ST_RESP;
          else                                                   state_nxt = ST_READ;
        end
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_MOD: begin
        cmd.mod_step   = 1'b1;
        cmd.probe_init = sts.mod_done;
      end
      ST_READ: begin
        cmd = '0;
      end
      ST_CHECK: begin
        if (sts.op_insert) begin
          if (sts.slot_free) begin
            cmd.wr_entry = 1'b1;
            cmd.set_ok   = 1'b1;
          end else begin
            cmd.advance = !sts.last_probe;
          end
        end else if (!sts.slot_empty) begin
          if (sts.key_match) begin
            cmd.set_ok    = 1'b1;
            cmd.set_found = 1'b1;
            cmd.wr_del    = sts.op_remove;
          end else begin
            cmd.advance = !sts.last_probe;
          end
        end
      end
      ST_RESP: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output valid flag: set on a result load, cleared once the beat is taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load)    out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

`ifndef SYNTHESIS
  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !cmd.out_load)
    else $error("result loaded over a pending beat");
`endif

endmodule

`default_nettype wire

>>> src/lpht_dpath.sv
// Datapath for the linear-probing hash table: request registers, home slot
// remainder unit, probe pointer, slot memory and result registers. Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dpath #(
  parameter int TABLE_DEPTH = lpht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = lpht_pkg::DEF_KEY_BITS,
  parameter int DATA_BITS   = lpht_pkg::DEF_DATA_BITS,
  parameter int SIZE_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [SIZE_W-1:0]                 act_size,
  input  wire logic [lpht_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [lpht_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic      [lpht_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic      [lpht_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  wire lpht_pkg::cmd_t                    cmd,
  output lpht_pkg::sts_t                         sts
);
  import lpht_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int REM_W   = SIZE_W + 1;
  localparam int ENTRY_W = KEY_BITS + DATA_BITS;

  // Request registers.
  logic [IN_TUSER_W-1:0] op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [DATA_BITS-1:0]  data_r;
  logic [HOME_W-1:0]     home_sh_r;

  // Remainder unit and probe state.
  logic [MOD_CNT_W-1:0]  mod_cnt_r;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [SIZE_W-1:0]     cnt_r;
  logic [SIZE_W-1:0]     pos_inc;
  logic [IDX_W-1:0]      clr_addr_r;

  // Slot memory.
  logic [ENTRY_W-1:0]    mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]    rd_data_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;

  // Result registers.
  logic                  res_status_r;
  logic [DATA_BITS-1:0]  res_found_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  logic slot_empty, slot_del;

  // Two restoring remainder steps per cycle on the home slot bits.
  always_comb begin
    logic [REM_W-1:0] rem_v;
    rem_v = rem_r;
    for (int i = 0; i < MOD_RADIX_BITS; i++) begin
      rem_v = {rem_v[REM_W-2:0], home_sh_r[HOME_W-1-i]};
      if (rem_v >= REM_W'(act_size)) rem_v = rem_v - REM_W'(act_size);
    end
    rem_nxt = rem_v;
  end

  // Next probe position, wrapping at the active size.
  assign pos_inc = SIZE_W'(pos_r) + SIZE_W'(1);
  assign pos_nxt = (pos_inc == act_size) ? '0 : IDX_W'(pos_inc);

  // Request capture, remainder iteration and probe pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser;
      key_r     <= in_tdata[KEY_LSB +: KEY_BITS];
      data_r    <= in_tdata[DATA_LSB +: DATA_BITS];
      home_sh_r <= in_tdata[HOME_LSB +: HOME_W];
      rem_r     <= '0;
    end else if (cmd.mod_step) begin
      home_sh_r <= home_sh_r << MOD_RADIX_BITS;
      rem_r     <= rem_nxt;
    end
    if (cmd.probe_init) begin
      pos_r <= IDX_W'(rem_nxt);
      cnt_r <= '0;
    end else if (cmd.advance) begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_r + SIZE_W'(1);
    end
  end

  // Remainder step counter and clearing address are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r  <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.load)          mod_cnt_r <= '0;
      else if (cmd.mod_step) mod_cnt_r <= mod_cnt_r + MOD_CNT_W'(1);
      if (cmd.clear_we)      clr_addr_r <= clr_addr_r + IDX_W'(1);
    end
  end

  // Single write port shared by the clearing pass, inserts and removals.
  always_comb begin
    mem_we    = cmd.clear_we || cmd.wr_entry || cmd.wr_del;
    mem_waddr = cmd.clear_we ? clr_addr_r : pos_r;
    if (cmd.clear_we)      mem_wdata = '0;
    else if (cmd.wr_entry) mem_wdata = {key_r, data_r};
    else                   mem_wdata = '1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[pos_r];
  end

  // Slot classification of the registered read.
  assign slot_empty = (rd_data_r == '0);
  assign slot_del   = (rd_data_r == '1);

  always_comb begin
    sts            = '0;
    sts.clear_done = (clr_addr_r == IDX_W'(TABLE_DEPTH - 1));
    sts.mod_done   = (mod_cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
    sts.op_insert  = (op_r == OP_INSERT);
    sts.op_lookup  = (op_r == OP_REMOVE) || (op_r == OP_SEARCH);
    sts.op_remove  = (op_r == OP_REMOVE);
    sts.slot_free  = slot_empty || slot_del;
    sts.slot_empty = slot_empty;
    sts.key_match  = !slot_del && (rd_data_r[ENTRY_W-1:DATA_BITS] == key_r);
    sts.last_probe = (cnt_r == act_size - SIZE_W'(1));
  end

  // Result accumulation and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= STATUS_FAIL;
      res_found_r  <= '0;
    end else begin
      if (cmd.set_ok)    res_status_r <= STATUS_OK;
      if (cmd.set_found) res_found_r  <= rd_data_r[DATA_BITS-1:0];
    end
    if (cmd.out_load) begin
      out_tdata_r <= OUT_TDATA_W'(res_found_r);
      out_tuser_r <= res_status_r;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

`ifndef SYNTHESIS
  // An insert only lands in an empty or deleted slot.
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_entry |-> (slot_empty || slot_del))
    else $error("insert wrote over a live slot");

  // A removal only marks a slot whose key matched.
  a_remove_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_del |-> (!slot_del && !slot_empty && cmd.set_found))
    else $error("removal without a key match");

  // After start or advance the probe pointer lies inside the active table.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.probe_init || cmd.advance) |=> (SIZE_W'(pos_r) < act_size))
    else $error("probe position beyond active table size");
`endif

endmodule

`default_nettype wire

>>> src/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing.
//
// Input channel in_*: one request per beat. in_tuser carries the operation
// (insert, remove, search); in_tdata carries key, data word and home slot.
// Output channel out_*: one result beat per request, data found in out_tdata
// and the status flag in out_tuser (low for success).
// Configuration: cfg_we with cfg_wdata sets the number of slots in use; a zero
// counts as one slot and a value above the depth counts as the full depth.
// Reset clears the configuration to 1024 slots and starts a clearing pass that
// zeroes the slot memory; in_tready stays low meanwhile.
// Sequence: once a request is accepted, the home slot is reduced modulo the
// active table size, two bits a cycle; each probe then takes a registered
// memory read and a step to inspect and write back through the single memory
// port, and the result is then loaded into the output register. An unused
// operation code probes nothing and goes straight to its result. Requests are
// served one at a time. A result waits in the output register while the
// receiver stalls; the next request is still accepted and worked on, and its
// result is loaded once the pending beat has been taken.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = lpht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = lpht_pkg::DEF_KEY_BITS,
  parameter int DATA_BITS   = lpht_pkg::DEF_DATA_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [lpht_pkg::CFG_W-1:0]        cfg_wdata,   // table_size
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: key [31:0], data_in [63:32], home_slot [73:64], zero [79:74]
  input  wire logic [lpht_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [lpht_pkg::IN_TUSER_W-1:0]   in_tuser,    // operation [1:0]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [lpht_pkg::OUT_TDATA_W-1:0]  out_tdata,   // data_out [31:0]
  output logic      [lpht_pkg::OUT_TUSER_W-1:0]  out_tuser    // status [0]
);
  import lpht_pkg::*;

  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);

  logic [CFG_W-1:0]  cfg_size_r;
  logic [31:0]       cfg_ext;
  logic [SIZE_W-1:0] act_size;
  cmd_t              cmd;
  sts_t              sts;

  // Table size register.
  always_ff @(posedge clk) begin
    if (!rst_n)      cfg_size_r <= CFG_SIZE_RESET;
    else if (cfg_we) cfg_size_r <= cfg_wdata;
  end

  // Effective size, clamped to one slot and to the memory depth.
  assign cfg_ext = 32'(cfg_size_r);
  always_comb begin
    if (cfg_ext == 32'd0)                  act_size = SIZE_W'(1);
    else if (cfg_ext > 32'(TABLE_DEPTH))   act_size = SIZE_W'(TABLE_DEPTH);
    else                                   act_size = SIZE_W'(cfg_ext);
  end

  lpht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lpht_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .DATA_BITS   (DATA_BITS),
    .SIZE_W      (SIZE_W)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .act_size  (act_size),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
